/* sv/pfm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfm_pkg
// Shared types and constants for the pluck excitation / feedback mixer.
// ----------------------------------------------------------------------------
package pfm_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int PERIOD_BITS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int MODE_BITS      = 2;

   // scale fraction bits (Q2.14)
   localparam int SCALE_FRAC = 14;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIX_FOREVER    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIX_PERIODS_Q8 = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOOP_SCALE     = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INIT_SCALE     = 2'd3;

   localparam logic signed [15:0] SCALE_RESET = 16'sd16384;

   // how a sample is rendered by the back end
   typedef enum logic [MODE_BITS-1:0] {
      MODE_MUTE,
      MODE_EXCITE,
      MODE_MIX,
      MODE_PASS
   } pfm_mode_type;

   typedef struct packed {
      logic               mix_forever;
      logic [15:0]        mix_periods_q8;
      logic signed [15:0] loop_scale;
      logic signed [15:0] init_scale;
   } pfm_cfg_type;

endpackage

/* sv/pfm_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfm_fifo
// Short register queue between the classifying front end and the datapath.
// ----------------------------------------------------------------------------
module pfm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
      if (p == PTR_BITS'(DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/pfm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfm_front
// Accepts samples, tracks cue and phase counters, tags each sample's mode.
// ----------------------------------------------------------------------------
module pfm_front
   import pfm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pfm_cfg_type                   cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_cue_level,
   input  logic [PERIOD_BITS-1:0]        req_delay_samples,
   input  logic signed [SAMPLE_BITS-1:0] req_feedback_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_excite_sample,
   input  logic                          q_full,
   output logic                          q_push,
   output logic [MODE_BITS+3*SAMPLE_BITS-1:0] q_data
);

   localparam int MIX_BITS  = PERIOD_BITS + 8;
   localparam int PROD_BITS = PERIOD_BITS + 16;

   logic                   muted_ff, muted_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic [MIX_BITS-1:0]    mix_ff, mix_in;
   logic [SAMPLE_BITS-1:0] held_ff, held_in;

   logic                   cue_nz;
   logic                   muted_n;
   logic [PERIOD_BITS-1:0] period_n;
   logic [MIX_BITS-1:0]    mix_n;
   logic [SAMPLE_BITS-1:0] held_n;
   logic [PROD_BITS-1:0]   mix_prod;
   pfm_mode_type           mode;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      cue_nz   = (req_cue_level != '0);
      mix_prod = PROD_BITS'(cfg.mix_periods_q8) * PROD_BITS'(req_delay_samples);
      held_n   = cue_nz ? req_cue_level : held_ff;
      period_n = cue_nz ? req_delay_samples : period_ff;
      mix_n    = cue_nz ? mix_prod[PROD_BITS-1:8] : mix_ff;
      muted_n  = cue_nz ? req_cue_level[SAMPLE_BITS-1] : muted_ff;

      period_in = period_n;
      mix_in    = mix_n;
      if (muted_n) begin
         mode = MODE_MUTE;
      end else if (period_n != '0) begin
         mode      = MODE_EXCITE;
         period_in = period_n - 1'b1;
      end else if (cfg.mix_forever || (mix_n != '0)) begin
         mode = MODE_MIX;
         if (!cfg.mix_forever) begin
            mix_in = mix_n - 1'b1;
         end
      end else begin
         mode = MODE_PASS;
      end
      muted_in = muted_n;
      held_in  = held_n;
   end

   assign q_data = {mode, held_n, req_feedback_sample, req_excite_sample};

   always_ff @(posedge clock) begin
      if (reset) begin
         muted_ff  <= 1'b1;
         period_ff <= '0;
         mix_ff    <= '0;
         held_ff   <= '0;
      end else if (q_push) begin
         muted_ff  <= muted_in;
         period_ff <= period_in;
         mix_ff    <= mix_in;
         held_ff   <= held_in;
      end
   end

endmodule

/* sv/pfm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfm_back
// Three-stage multiply, mix and saturate datapath with the output register.
// ----------------------------------------------------------------------------
module pfm_back
   import pfm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pfm_cfg_type                        cfg,
   input  logic                               q_empty,
   input  logic [MODE_BITS+3*SAMPLE_BITS-1:0] q_data,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_out_sample
);

   localparam int S   = SAMPLE_BITS;
   localparam int AW  = S + 18;
   localparam logic signed [S-1:0] SMAX = {1'b0, {(S-1){1'b1}}};
   localparam logic signed [S-1:0] SMIN = {1'b1, {(S-1){1'b0}}};

   logic                 advance;
   pfm_mode_type         q_mode;
   logic signed [S-1:0]  q_held, q_fb, q_ex;

   // stage a: cue times excitation
   logic                 valid_a_ff;
   pfm_mode_type         mode_a_ff;
   logic signed [S-1:0]  fb_a_ff;
   logic signed [2*S-1:0] prod_a_ff;

   // stage b: scaled feedback and scaled excitation
   logic                 valid_b_ff;
   pfm_mode_type         mode_b_ff;
   logic signed [S-1:0]  fb_b_ff;
   logic signed [S:0]    ce_b_ff;
   logic signed [S+15:0] loop_prod_b_ff;
   logic signed [S+16:0] init_prod_b_ff;

   logic signed [2*S-1:0] ce_full;
   logic signed [S:0]     ce_a;
   logic signed [S+15:0]  loop_prod_in;
   logic signed [S+16:0]  init_prod_in;

   logic signed [AW-1:0] mix_sum, mix_sh;
   logic signed [S-1:0]  ce_sat, mix_sat;

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [S-1:0] rsp_out_ff, rsp_out_in;

   assign advance = !(rsp_valid_ff && !rsp_ready);
   assign q_pop   = advance && !q_empty;

   assign q_mode = pfm_mode_type'(q_data[MODE_BITS+3*S-1:3*S]);
   assign q_held = q_data[3*S-1:2*S];
   assign q_fb   = q_data[2*S-1:S];
   assign q_ex   = q_data[S-1:0];

   always_comb begin
      ce_full      = prod_a_ff >>> (S - 1);
      ce_a         = ce_full[S:0];
      loop_prod_in = cfg.loop_scale * fb_a_ff;
      init_prod_in = cfg.init_scale * ce_a;
   end

   always_comb begin
      mix_sum = {{2{loop_prod_b_ff[S+15]}}, loop_prod_b_ff}
              + {init_prod_b_ff[S+16], init_prod_b_ff};
      mix_sh  = mix_sum >>> SCALE_FRAC;

      // clamp when the bits above the sample range disagree with its sign
      if (ce_b_ff[S] == ce_b_ff[S-1]) begin
         ce_sat = ce_b_ff[S-1:0];
      end else begin
         ce_sat = ce_b_ff[S] ? SMIN : SMAX;
      end
      if ((mix_sh[AW-1:S-1] == '0) || (mix_sh[AW-1:S-1] == '1)) begin
         mix_sat = mix_sh[S-1:0];
      end else begin
         mix_sat = mix_sh[AW-1] ? SMIN : SMAX;
      end

      unique case (mode_b_ff)
         MODE_MUTE:   rsp_out_in = '0;
         MODE_EXCITE: rsp_out_in = ce_sat;
         MODE_MIX:    rsp_out_in = mix_sat;
         MODE_PASS:   rsp_out_in = fb_b_ff;
         default:     rsp_out_in = '0;
      endcase
      rsp_valid_in = valid_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff   <= 1'b0;
         valid_b_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff   <= q_pop;
         valid_b_ff   <= valid_a_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode_a_ff      <= q_mode;
         fb_a_ff        <= q_fb;
         prod_a_ff      <= q_held * q_ex;
         mode_b_ff      <= mode_a_ff;
         fb_b_ff        <= fb_a_ff;
         ce_b_ff        <= ce_a;
         loop_prod_b_ff <= loop_prod_in;
         init_prod_b_ff <= init_prod_in;
         rsp_out_ff     <= rsp_out_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_out_ff;

endmodule

/* sv/pluck_excitation_feedback_mixer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pluck_excitation_feedback_mixer
// Per-sample pluck excitation and string feedback mixer with saturation.
//
//   channel  dir   transfer when        payload
//   req_     in    req_valid&req_ready  cue_level, delay_samples,
//                                       feedback_sample, excite_sample
//   rsp_     out   rsp_valid&rsp_ready  out_sample
//   csr_     in    csr_we               csr_index, csr_wdata
//
// one sample per cycle sustained while rsp_ready stays high; each result passes
// the queue write, product stage, scale stage and output register in that order
// the front end takes a sample whenever the queue has room, so input
// transfers continue while a result waits on rsp_ready, up to the queue depth
// synchronous reset clears the cue/phase state (muted) and loads the
// register defaults; no clearing pass
// ----------------------------------------------------------------------------
module pluck_excitation_feedback_mixer
   import pfm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int PERIOD_BITS = PERIOD_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // sample input
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_cue_level,
   input  logic [PERIOD_BITS-1:0]        req_delay_samples,
   input  logic signed [SAMPLE_BITS-1:0] req_feedback_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_excite_sample,
   // sample output
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_sample,
   // register writes
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int QW = MODE_BITS + 3 * SAMPLE_BITS;

   pfm_cfg_type   cfg_ff, cfg_in;

   logic          q_push, q_pop, q_full, q_empty;
   logic [QW-1:0] q_wdata, q_rdata;

   // register file; the user must write it only while the mixer is idle, the block does not enforce this
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MIX_FOREVER:    cfg_in.mix_forever    = csr_wdata[0];
            CSR_MIX_PERIODS_Q8: cfg_in.mix_periods_q8 = csr_wdata;
            CSR_LOOP_SCALE:     cfg_in.loop_scale     = csr_wdata;
            CSR_INIT_SCALE:     cfg_in.init_scale     = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mix_forever    <= 1'b0;
         cfg_ff.mix_periods_q8 <= '0;
         cfg_ff.loop_scale     <= SCALE_RESET;
         cfg_ff.init_scale     <= SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: cue latch, phase counters, mode tag
   pfm_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .PERIOD_BITS (PERIOD_BITS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cue_level       (req_cue_level),
      .req_delay_samples   (req_delay_samples),
      .req_feedback_sample (req_feedback_sample),
      .req_excite_sample   (req_excite_sample),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_data              (q_wdata)
   );

   // decoupling queue
   pfm_fifo #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .full      (q_full),
      .empty     (q_empty)
   );

   // back end: multiply, mix, saturate, hold result
   pfm_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_empty        (q_empty),
      .q_data         (q_rdata),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_sample (rsp_out_sample)
   );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for pluck_excitation_feedback_mixer. A table of
// directed samples and register writes runs first, then randomized phases:
// each phase reprograms the mixer registers while idle and streams plucks
// with random content. An in-bench model of the cue/phase state predicts
// every output sample, and a scoreboard compares each rsp_ transfer in order.
// The sender works in random bursts and the receiver stalls in changing
// patterns.
// ----------------------------------------------------------------------------
module tb_top
   import pfm_pkg::*;
();

   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 10;       // idle margin after the last result drains
   localparam int CYCLE_LIMIT   = 400000;
   localparam int MAX_REPORTS   = 10;
   localparam int RAND_PHASES   = 12;
   localparam int PHASE_SAMPLES = 161;
   localparam int MIX_BITS      = PERIOD_BITS_DEF + 8;

   localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS_DEF - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

   typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_type;
   typedef logic [PERIOD_BITS_DEF-1:0]        period_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   // one line of the directed table: a sample transfer or a register write
   typedef struct packed {
      row_kind_type              kind;
      sample_type                cue;
      period_type                delay;
      sample_type                fb;
      sample_type                ex;
      logic                      checked;     // expected value typed in
      sample_type                typed_out;
      logic [CSR_INDEX_BITS-1:0] reg_index;
      logic [CSR_DATA_BITS-1:0]  reg_data;
   } stim_row_type;

   // dut signals, all inputs known from time zero
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   sample_type                req_cue_level = '0;
   period_type                req_delay_samples = '0;
   sample_type                req_feedback_sample = '0;
   sample_type                req_excite_sample = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   sample_type                rsp_out_sample;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // register shadow, reset values
   logic           cfg_mix_forever = 1'b0;
   logic [15:0]    cfg_mix_periods = '0;
   logic signed [15:0] cfg_loop_scale = SCALE_RESET;
   logic signed [15:0] cfg_init_scale = SCALE_RESET;

   // cue / phase state of the mixer, reset values
   logic                st_muted = 1'b1;
   period_type          st_period_left = '0;
   logic [MIX_BITS-1:0] st_mix_left = '0;
   sample_type          st_held_cue = '0;

   sample_type   expected_samples[$];
   sample_type   want_sample;
   stim_row_type directed_rows[$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           burst_left = 0;

   pluck_excitation_feedback_mixer uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cue_level       (req_cue_level),
      .req_delay_samples   (req_delay_samples),
      .req_feedback_sample (req_feedback_sample),
      .req_excite_sample   (req_excite_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_sample      (rsp_out_sample),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // output prediction
   // ------------------------------------------------------------------------

   function automatic sample_type clamp_sample(input longint value);
      if (value > SAMPLE_MAX) return sample_type'(SAMPLE_MAX);
      if (value < SAMPLE_MIN) return sample_type'(SAMPLE_MIN);
      return sample_type'(value);
   endfunction

   // advances the cue/phase state by one sample and returns its output
   task automatic mix_predict(input sample_type cue, input period_type delay,
                              input sample_type fb, input sample_type ex,
                              output sample_type out);
      longint cue_ex;
      longint acc;
      // any nonzero cue re-arms the excitation period and the mix length
      if (cue != 0) begin
         st_held_cue    = cue;
         st_period_left = delay;
         st_mix_left    = MIX_BITS'((32'(cfg_mix_periods) * 32'(delay)) >> 8);
         st_muted       = (cue < 0);
      end
      // cue times excitation, floored, kept wide (can reach +1.0)
      cue_ex = (longint'(st_held_cue) * longint'(ex)) >>> (SAMPLE_BITS_DEF - 1);
      if (st_muted) begin
         out = '0;
      end else if (st_period_left != 0) begin
         out = clamp_sample(cue_ex);
         st_period_left = st_period_left - 1'b1;
      end else if (cfg_mix_forever || st_mix_left != 0) begin
         acc = longint'(cfg_loop_scale) * longint'(fb)
             + longint'(cfg_init_scale) * cue_ex;
         out = clamp_sample(acc >>> SCALE_FRAC);
         // endless mixing freezes the remaining length
         if (!cfg_mix_forever) st_mix_left = st_mix_left - 1'b1;
      end else begin
         out = fb;
      end
   endtask

   // ------------------------------------------------------------------------
   // driving
   // ------------------------------------------------------------------------

   // one register write, after which the enable is driven low before the task returns
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_MIX_FOREVER:    cfg_mix_forever = data[0];
         CSR_MIX_PERIODS_Q8: cfg_mix_periods = data;
         CSR_LOOP_SCALE:     cfg_loop_scale  = data;
         CSR_INIT_SCALE:     cfg_init_scale  = data;
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending and let every outstanding result drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one input transfer in a burst; the prediction is queued on acceptance
   task automatic send_sample(input sample_type cue, input period_type delay,
                              input sample_type fb, input sample_type ex,
                              input logic checked, input sample_type typed_out);
      int         gap;
      sample_type predicted;
      if (burst_left == 0) begin
         // a zero gap keeps valid up across bursts
         gap = ($urandom_range(0, 3) == 0) ? 0
             : ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30)
             : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                    : $urandom_range(1, 30);
      end
      burst_left--;
      req_valid           <= 1'b1;
      req_cue_level       <= cue;
      req_delay_samples   <= delay;
      req_feedback_sample <= fb;
      req_excite_sample   <= ex;
      do @(posedge clock); while (!req_ready);
      mix_predict(cue, delay, fb, ex, predicted);
      expected_samples.push_back(checked ? typed_out : predicted);
   endtask

   function automatic sample_type rand_sample();
      case ($urandom_range(0, 19))
         0:       return sample_type'(SAMPLE_MIN);
         1:       return sample_type'(SAMPLE_MAX);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic stim_row_type sample_row(input sample_type cue,
                                               input period_type delay,
                                               input sample_type fb,
                                               input sample_type ex);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_SAMPLE;
      row.cue   = cue;
      row.delay = delay;
      row.fb    = fb;
      row.ex    = ex;
      return row;
   endfunction

   function automatic stim_row_type checked_row(input sample_type cue,
                                                input period_type delay,
                                                input sample_type fb,
                                                input sample_type ex,
                                                input sample_type out);
      stim_row_type row;
      row           = sample_row(cue, delay, fb, ex);
      row.checked   = 1'b1;
      row.typed_out = out;
      return row;
   endfunction

   function automatic stim_row_type write_row(input logic [CSR_INDEX_BITS-1:0] idx,
                                              input logic [CSR_DATA_BITS-1:0] data);
      stim_row_type row;
      row           = '0;
      row.kind      = ROW_WRITE;
      row.reg_index = idx;
      row.reg_data  = data;
      return row;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------

   initial begin : stimulus
      sample_type  cue;
      period_type  delay;
      int          pick;
      logic [15:0] periods;
      logic [15:0] loop_gain;
      logic [15:0] init_gain;

      // silent until the first cue
      directed_rows.push_back(checked_row(0, 5, 1234, 999, 0));
      directed_rows.push_back(checked_row(0, 16'hFFFF, -32768, 32767, 0));
      // full-scale pluck: excitation at the product extreme
      directed_rows.push_back(checked_row(32767, 2, 100, -32768, -32767));
      directed_rows.push_back(checked_row(0, 0, -5, 32767, 32766));
      // zero mix length, feedback passes straight after the period
      directed_rows.push_back(checked_row(0, 0, 7, 0, 7));
      directed_rows.push_back(checked_row(0, 0, -32768, 123, -32768));
      // negative cue mutes until the next positive one
      directed_rows.push_back(checked_row(-1, 9, 500, 500, 0));
      directed_rows.push_back(checked_row(0, 0, 500, 500, 0));
      // one-period mix; zero delay leaves nothing to mix
      directed_rows.push_back(write_row(CSR_MIX_PERIODS_Q8, 16'd256));
      directed_rows.push_back(checked_row(16384, 0, 1000, 2000, 1000));
      // short pluck through excite, mix and pass
      directed_rows.push_back(sample_row(16384, 3, 1000, 2000));
      directed_rows.push_back(sample_row(0, 0, -1000, 2000));
      directed_rows.push_back(sample_row(0, 0, 3000, -7000));
      directed_rows.push_back(sample_row(0, 0, 1000, 2000));
      directed_rows.push_back(sample_row(0, 0, -20000, 32767));
      directed_rows.push_back(sample_row(0, 0, 22222, -32768));
      directed_rows.push_back(sample_row(0, 0, 1111, 4444));
      // endless mixing starting at once on a zero delay
      directed_rows.push_back(write_row(CSR_MIX_FOREVER, 16'd1));
      directed_rows.push_back(checked_row(16384, 0, 1000, 2000, 2000));
      // most negative gains drive the sum into both rails
      directed_rows.push_back(write_row(CSR_LOOP_SCALE, 16'h8000));
      directed_rows.push_back(write_row(CSR_INIT_SCALE, 16'h8000));
      directed_rows.push_back(checked_row(32767, 0, -32768, -32768, 32767));
      directed_rows.push_back(checked_row(0, 0, 32767, 32767, -32768));
      directed_rows.push_back(write_row(CSR_INIT_SCALE, 16'h7FFF));
      directed_rows.push_back(write_row(CSR_LOOP_SCALE, 16'h0000));
      directed_rows.push_back(sample_row(0, 0, 32767, 32767));
      // leaving endless mixing with no length left falls back to pass
      directed_rows.push_back(write_row(CSR_MIX_FOREVER, 16'd0));
      directed_rows.push_back(checked_row(0, 0, 4321, -1, 4321));
      // largest mix-periods setting, plucked with a one-sample delay
      directed_rows.push_back(write_row(CSR_MIX_PERIODS_Q8, 16'hFFFF));
      directed_rows.push_back(write_row(CSR_LOOP_SCALE, SCALE_RESET));
      directed_rows.push_back(write_row(CSR_INIT_SCALE, SCALE_RESET));
      directed_rows.push_back(sample_row(20000, 1, 300, 30000));
      directed_rows.push_back(sample_row(0, 16'hFFFF, -300, -30000));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            wait_idle();
            write_reg(directed_rows[i].reg_index, directed_rows[i].reg_data);
         end else begin
            send_sample(directed_rows[i].cue, directed_rows[i].delay,
                        directed_rows[i].fb, directed_rows[i].ex,
                        directed_rows[i].checked, directed_rows[i].typed_out);
         end
      end

      // random phases: new register set, then a stream of plucks
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph % 4)
            0:       periods = 16'd0;
            1:       periods = 16'hFFFF;
            2:       periods = 16'd256;
            default: periods = 16'($urandom_range(1, 1024));
         endcase
         case (ph)
            0:       begin loop_gain = 16'h8000; init_gain = 16'h7FFF; end
            1:       begin loop_gain = 16'h7FFF; init_gain = 16'h8000; end
            2:       begin loop_gain = 16'h0000; init_gain = 16'h4000; end
            3:       begin loop_gain = 16'h4000; init_gain = 16'h0000; end
            default: begin loop_gain = 16'($urandom); init_gain = 16'($urandom); end
         endcase
         wait_idle();
         // upper bits of the enable write are don't-care, drive them random
         write_reg(CSR_MIX_FOREVER, {15'($urandom), 1'(ph % 3 == 1)});
         write_reg(CSR_MIX_PERIODS_Q8, periods);
         write_reg(CSR_LOOP_SCALE, loop_gain);
         write_reg(CSR_INIT_SCALE, init_gain);

         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            pick  = $urandom_range(0, 99);
            cue   = '0;
            delay = period_type'($urandom);    // ignored without a cue
            if (pick < 5) begin
               // pluck, mostly short loops so every phase is reached
               case ($urandom_range(0, 9))
                  0:       cue = sample_type'(SAMPLE_MAX);
                  1:       cue = 1;
                  default: cue = sample_type'($urandom_range(1, 32767));
               endcase
               case ($urandom_range(0, 19))
                  0:       delay = period_type'($urandom);
                  1, 2:    delay = period_type'($urandom_range(25, 400));
                  default: delay = period_type'($urandom_range(0, 24));
               endcase
            end else if (pick < 7) begin
               // mute
               cue = ($urandom_range(0, 3) == 0) ? sample_type'(SAMPLE_MIN)
                   : -sample_type'($urandom_range(1, 32767));
            end
            send_sample(cue, delay, rand_sample(), rand_sample(), 1'b0, '0);
         end
      end

      wait_idle();
      if (mismatch_count == 0 && expected_samples.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // receiver and checking
   // ------------------------------------------------------------------------

   // back-pressure mode steps with bits 10:9 of the cycle counter: none, random, one in four,
   // long stalls that fill the input queue
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      case (cycle_count[10:9])
         2'd0:    rsp_ready <= 1'b1;
         2'd1:    rsp_ready <= 1'($urandom_range(0, 1));
         2'd2:    rsp_ready <= (cycle_count[1:0] == 2'd0);
         default: rsp_ready <= (cycle_count[4:3] == 2'd0);
      endcase
   end

   // every rsp_ transfer is matched against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("cycle %0d: unexpected output transfer, out_sample %0d",
                        cycle_count, rsp_out_sample);
         end else begin
            want_sample = expected_samples.pop_front();
            if (rsp_out_sample !== want_sample) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("cycle %0d: out_sample mismatch, expected %0d, got %0d",
                           cycle_count, want_sample, rsp_out_sample);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cycle limit reached with %0d outputs outstanding",
                  expected_samples.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule

/* files.f */
sv/pfm_pkg.sv
sv/pfm_fifo.sv
sv/pfm_front.sv
sv/pfm_back.sv
sv/pluck_excitation_feedback_mixer.sv
dv/tb_top.sv
